/* rtl/tts_pkg.sv */
// Shared types and constants for the tick task scheduler table.
// No dependencies; compile first.
`default_nettype none

package tts_pkg;

   localparam int HANDLE_W          = 8;
   localparam int TIME_W            = 16;
   localparam int SLOT_W            = 4;
   localparam int RUNS_W            = 8;
   localparam int KIND_W            = 3;
   localparam int DEFAULT_NUM_SLOTS = 8;

   localparam logic [RUNS_W-1:0] RUNS_MAX = {RUNS_W{1'b1}};

   // result kinds
   localparam logic [KIND_W-1:0] KIND_ADD  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DEL  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_TICK = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DUE  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_NONE = 3'd4;

   typedef enum logic [1:0] {
      OP_ADD  = 2'd0,
      OP_DEL  = 2'd1,
      OP_TICK = 2'd2,
      OP_DISP = 2'd3
   } op_type;

   typedef struct packed {
      op_type              op;
      logic                in_range;
      logic [HANDLE_W-1:0] task_handle;
      logic [TIME_W-1:0]   first_delay;
      logic [TIME_W-1:0]   repeat_period;
      logic [SLOT_W-1:0]   slot;
   } cmd_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_q_type;

   // back end status returned to the front end
   typedef struct packed {
      logic pop;
      logic busy;
   } back_stat_type;

endpackage

`default_nettype wire

/* rtl/tts_ifs.sv */
// Request and response channel interfaces for the scheduler table.
// Depends on tts_pkg for field widths.
`default_nettype none

interface tts_req_if;
   import tts_pkg::*;
   logic                valid;
   logic                ready;
   logic [1:0]          op;
   logic [HANDLE_W-1:0] task_handle;
   logic [TIME_W-1:0]   first_delay;
   logic [TIME_W-1:0]   repeat_period;
   logic [SLOT_W-1:0]   slot;

   modport source (output valid, op, task_handle, first_delay, repeat_period, slot,
                   input ready);
   modport sink   (input valid, op, task_handle, first_delay, repeat_period, slot,
                   output ready);
endinterface

interface tts_rsp_if;
   import tts_pkg::*;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [SLOT_W-1:0]   result_slot;
   logic [HANDLE_W-1:0] due_handle;
   logic                ok;
   logic                last;

   modport source (output valid, kind, result_slot, due_handle, ok, last,
                   input ready);
   modport sink   (input valid, kind, result_slot, due_handle, ok, last,
                   output ready);
endinterface

`default_nettype wire

/* rtl/tts_front.sv */
// Front end: accepts request words, decodes them into commands and
// holds them in a two-entry queue. Depends on tts_pkg and tts_ifs.
`default_nettype none

module tts_front
   import tts_pkg::*;
#(
   parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS
) (
   input  logic          clock,
   input  logic          reset,
   tts_req_if.sink       req,
   output cmd_q_type     head,
   input  back_stat_type stat
);

   cmd_type    queue_ff [2];
   cmd_type    cmd_dec;
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       push;

   assign req.ready = (count_ff != 2'd2);
   assign push      = req.valid && req.ready;

   // decode the request word
   always_comb begin
      cmd_dec.op            = op_type'(req.op);
      cmd_dec.in_range      = (req.slot < SLOT_W'(NUM_SLOTS));
      cmd_dec.task_handle   = req.task_handle;
      cmd_dec.first_delay   = req.first_delay;
      cmd_dec.repeat_period = req.repeat_period;
      cmd_dec.slot          = req.slot;
   end

   always_comb begin
      wr_ptr_in = push     ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = stat.pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !stat.pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && stat.pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_dec;
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.cmd   = queue_ff[rd_ptr_ff];

endmodule

`default_nettype wire

/* rtl/tts_back.sv */
// Back end: slot table, per-slot tick and dispatch sequencer and the
// response output register. Depends on tts_pkg and tts_ifs.
`default_nettype none

module tts_back
   import tts_pkg::*;
#(
   parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS
) (
   input  logic          clock,
   input  logic          reset,
   input  cmd_q_type     head,
   output back_stat_type stat,
   tts_rsp_if.source     rsp
);

   localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SLOTS - 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_TICK = 3'b010,
      ST_DISP = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [IdxW-1:0] idx_ff, idx_in;

   logic [HANDLE_W-1:0] handle_ff [NUM_SLOTS];
   logic [HANDLE_W-1:0] handle_in [NUM_SLOTS];
   logic [TIME_W-1:0]   count_ff  [NUM_SLOTS];
   logic [TIME_W-1:0]   count_in  [NUM_SLOTS];
   logic [TIME_W-1:0]   period_ff [NUM_SLOTS];
   logic [TIME_W-1:0]   period_in [NUM_SLOTS];
   logic [RUNS_W-1:0]   runs_ff   [NUM_SLOTS];
   logic [RUNS_W-1:0]   runs_in   [NUM_SLOTS];

   logic                rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [SLOT_W-1:0]   rslot_ff, rslot_in;
   logic [HANDLE_W-1:0] dhandle_ff, dhandle_in;
   logic                ok_ff, ok_in;
   logic                last_ff, last_in;

   logic [NUM_SLOTS-1:0] pend_nz;
   logic                 above_nz;
   logic                 free_found;
   logic [IdxW-1:0]      free_idx;
   logic [IdxW-1:0]      del_idx;
   logic                 out_free;
   logic                 pop;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign del_idx  = head.cmd.slot[IdxW-1:0];

   // slot status vectors and lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      above_nz   = 1'b0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         pend_nz[i] = (runs_ff[i] != '0);
         if (handle_ff[i] == '0) begin
            free_found = 1'b1;
            free_idx   = IdxW'(i);
         end
         if (pend_nz[i] && (IdxW'(i) > idx_ff)) begin
            above_nz = 1'b1;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      handle_in    = handle_ff;
      count_in     = count_ff;
      period_in    = period_ff;
      runs_in      = runs_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      kind_in      = kind_ff;
      rslot_in     = rslot_ff;
      dhandle_in   = dhandle_ff;
      ok_in        = ok_ff;
      last_in      = last_ff;
      pop          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (head.valid && out_free) begin
               pop = 1'b1;
               case (head.cmd.op)
                  OP_ADD: begin
                     rsp_valid_in = 1'b1;
                     kind_in      = KIND_ADD;
                     dhandle_in   = '0;
                     last_in      = 1'b1;
                     if (free_found) begin
                        handle_in[free_idx] = head.cmd.task_handle;
                        count_in[free_idx]  = head.cmd.first_delay;
                        period_in[free_idx] = head.cmd.repeat_period;
                        runs_in[free_idx]   = '0;
                        rslot_in            = SLOT_W'(free_idx);
                        ok_in               = 1'b1;
                     end else begin
                        rslot_in = SLOT_W'(NUM_SLOTS);
                        ok_in    = 1'b0;
                     end
                  end
                  OP_DEL: begin
                     rsp_valid_in = 1'b1;
                     kind_in      = KIND_DEL;
                     rslot_in     = head.cmd.slot;
                     dhandle_in   = '0;
                     ok_in        = head.cmd.in_range;
                     last_in      = 1'b1;
                     if (head.cmd.in_range) begin
                        handle_in[del_idx] = '0;
                        count_in[del_idx]  = '0;
                        period_in[del_idx] = '0;
                        runs_in[del_idx]   = '0;
                     end
                  end
                  OP_TICK: begin
                     state_in = ST_TICK;
                     idx_in   = '0;
                  end
                  OP_DISP: begin
                     if (|pend_nz) begin
                        state_in = ST_DISP;
                        idx_in   = '0;
                     end else begin
                        rsp_valid_in = 1'b1;
                        kind_in      = KIND_NONE;
                        rslot_in     = '0;
                        dhandle_in   = '0;
                        ok_in        = 1'b1;
                        last_in      = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_TICK: begin
            // hold on the final slot until the response register is free
            if (idx_ff != LastIdx || out_free) begin
               if (handle_ff[idx_ff] != '0) begin
                  if (count_ff[idx_ff] == '0) begin
                     if (runs_ff[idx_ff] != RUNS_MAX) begin
                        runs_in[idx_ff] = runs_ff[idx_ff] + RUNS_W'(1);
                     end
                     if (period_ff[idx_ff] != '0) begin
                        count_in[idx_ff] = period_ff[idx_ff];
                     end
                  end else begin
                     count_in[idx_ff] = count_ff[idx_ff] - TIME_W'(1);
                  end
               end
               if (idx_ff == LastIdx) begin
                  rsp_valid_in = 1'b1;
                  kind_in      = KIND_TICK;
                  rslot_in     = '0;
                  dhandle_in   = '0;
                  ok_in        = 1'b1;
                  last_in      = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  idx_in = idx_ff + IdxW'(1);
               end
            end
         end

         ST_DISP: begin
            if (pend_nz[idx_ff]) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  kind_in      = KIND_DUE;
                  rslot_in     = SLOT_W'(idx_ff);
                  dhandle_in   = handle_ff[idx_ff];
                  ok_in        = 1'b1;
                  last_in      = !above_nz;
                  runs_in[idx_ff] = runs_ff[idx_ff] - RUNS_W'(1);
                  // one-shot slots are freed once reported
                  if (period_ff[idx_ff] == '0) begin
                     handle_in[idx_ff] = '0;
                     count_in[idx_ff]  = '0;
                     runs_in[idx_ff]   = '0;
                  end
                  if (!above_nz || idx_ff == LastIdx) begin
                     state_in = ST_IDLE;
                  end else begin
                     idx_in = idx_ff + IdxW'(1);
                  end
               end
            end else if (idx_ff == LastIdx) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + IdxW'(1);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            handle_ff[i] <= '0;
            count_ff[i]  <= '0;
            period_ff[i] <= '0;
            runs_ff[i]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         handle_ff    <= handle_in;
         count_ff     <= count_in;
         period_ff    <= period_in;
         runs_ff      <= runs_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      rslot_ff   <= rslot_in;
      dhandle_ff <= dhandle_in;
      ok_ff      <= ok_in;
      last_ff    <= last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.kind        = kind_ff;
   assign rsp.result_slot = rslot_ff;
   assign rsp.due_handle  = dhandle_ff;
   assign rsp.ok          = ok_ff;
   assign rsp.last        = last_ff;

   assign stat.pop  = pop;
   assign stat.busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

/* rtl/tick_task_scheduler_table.sv */
// Tick task scheduler table, top level.
// Depends on tts_pkg, tts_ifs, tts_front and tts_back.
//
// req_bus carries one command word per valid/ready handshake: add a task to
// the lowest free slot, delete a slot, advance all slots by one tick, or
// dispatch due tasks. rsp_bus returns result words; every command gives one
// word, except a dispatch with pending runs, which gives one word per such
// slot in ascending slot order. The final word of a command has last set.
// A two-entry command queue sits between the request side and the slot
// sequencer, so new commands are taken while a result waits on rsp_bus.
// Add, delete and an empty dispatch are answered from the queue entry through
// the response register. A tick walks the slots one per cycle, holding on the
// last slot while the response register is full; a dispatch walks the slots
// the same way, holding on each due slot while the response register is full,
// and stops after the highest due slot. The sequencer takes no new command
// until its walk is done.
// When rsp_bus stalls, the sequencer holds its place and the queue fills,
// then req_bus ready drops. Synchronous reset empties the queue, drops
// rsp_bus valid and clears every slot at once.
`default_nettype none

module tick_task_scheduler_table
   import tts_pkg::*;
#(
   parameter int NUM_SLOTS = DEFAULT_NUM_SLOTS
) (
   input  logic      clock,
   input  logic      reset,
   tts_req_if.sink   req_bus,
   tts_rsp_if.source rsp_bus
);

   cmd_q_type     head;
   back_stat_type stat;

   tts_front #(
      .NUM_SLOTS(NUM_SLOTS)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .head  (head),
      .stat  (stat)
   );

   tts_back #(
      .NUM_SLOTS(NUM_SLOTS)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .stat  (stat),
      .rsp   (rsp_bus)
   );

`ifndef ASSERT_OFF
   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      stat.pop |-> head.valid)
      else $error("command popped from empty queue");

   a_accept_fills_queue: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> head.valid)
      else $error("accepted word missing from queue");

   a_no_pop_while_busy: assert property (@(posedge clock) disable iff (reset)
      stat.busy |-> !stat.pop)
      else $error("command popped during slot walk");

   a_due_is_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.kind == KIND_DUE) |-> (rsp_bus.ok && rsp_bus.due_handle != '0))
      else $error("due word without live handle");
`endif

endmodule

`default_nettype wire
